[rtl/ggnh_pkg.sv]
// Shared types and codes for the greedy geographic next-hop selector.
package ggnh_pkg;

    // Input item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ROUTE = 1'b1;

    // Route result codes.
    localparam logic [1:0] ROUTE_SINK = 2'd0;
    localparam logic [1:0] ROUTE_NODE = 2'd1;
    localparam logic [1:0] ROUTE_NONE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SINK_X    = 3'd0;
    localparam logic [2:0] REG_SINK_Y    = 3'd1;
    localparam logic [2:0] REG_RANGE     = 3'd2;
    localparam logic [2:0] REG_CAP       = 3'd3;
    localparam logic [2:0] REG_NODE_CNT  = 3'd4;

    // Width of the reported relay index.
    localparam int unsigned NEXT_W = 7;

    // Tag that travels with each beat through the distance pipeline.
    typedef struct packed {
        logic              beat;     // a beat is present in this stage
        logic              sink;     // beat carries the sink position itself
        logic              node_ok;  // beat carries a table entry below node_count
        logic              last;     // final beat of the scan
        logic [NEXT_W-1:0] idx;      // low bits of the table slot
    } t_tag;

endpackage

[rtl/greedy_geographic_next_hop.sv]
// Top level of the greedy geographic next-hop selector: cell chain, sequencer and registers.
//
// A load item writes one table slot in the cycle it is accepted and leaves busy low.
// For a route item the node table, a ring of MAX_NODES cells, rotates one slot per
// cycle past a single four-stage distance pipeline, after one extra beat that checks
// the sink itself, and the whole ring always turns once so the slots come back to
// their home cells. The result then passes into the output register. busy falls in
// the cycle the result is shown, so the next item can be accepted in that cycle.
// o_valid is high for one cycle per route item and the result must be taken in that
// cycle.
module greedy_geographic_next_hop #(
    parameter int MAX_NODES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [6:0]  i_node_index,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_route,
    output logic [6:0]  o_next_node
);

    import ggnh_pkg::*;

    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int CW = (SW > 8) ? SW : 8;
    localparam int KW = (SW > 7) ? SW : 7;

    // Configuration registers.
    logic signed [15:0] r_sink_x, r_sink_y;
    logic [15:0]        r_radio_range, r_cap;
    logic [7:0]         r_node_count;

    // Sequencer.
    logic               r_busy, r_feed;
    logic [SW-1:0]      r_step;
    logic signed [15:0] r_pkt_x, r_pkt_y;
    logic               r_out_valid;
    logic [1:0]         r_out_route;
    logic [6:0]         r_out_next;

    logic               accept, load, route_go, shift;
    logic [SW-1:0]      slot;
    logic [SW+6:0]      slot_ext;
    logic               step_last;
    t_tag               tag;
    logic signed [15:0] head_x, head_y;
    logic               fin;
    logic [1:0]         ev_route;
    logic [NEXT_W-1:0]  ev_next;

    logic signed [15:0] cell_x [MAX_NODES];
    logic signed [15:0] cell_y [MAX_NODES];

    assign accept   = start && !r_busy;
    assign load     = accept && (i_kind == KIND_LOAD);
    assign route_go = accept && (i_kind == KIND_ROUTE);

    // Step 0 is the sink beat; step s carries table slot s-1, now at the head cell.
    assign slot      = r_step - SW'(1);
    assign slot_ext  = {7'd0, slot};
    assign step_last = r_step == SW'(MAX_NODES);
    assign shift     = r_feed && (r_step != '0);

    always_comb begin
        tag         = '0;
        tag.beat    = r_feed;
        tag.sink    = r_step == '0;
        tag.node_ok = (r_step != '0) && (CW'(slot) < CW'(r_node_count));
        tag.last    = step_last;
        tag.idx     = slot_ext[NEXT_W-1:0];
    end

    assign head_x = tag.sink ? r_sink_x : cell_x[0];
    assign head_y = tag.sink ? r_sink_y : cell_y[0];

    genvar k;
    generate
        for (k = 0; k < MAX_NODES; k++) begin : g_cell
            logic wr;
            assign wr = load && (KW'(i_node_index) == KW'(k));
            ggnh_cell u_cell (
                .i_clk   (i_clk),
                .i_wr    (wr),
                .i_wr_x  (i_pos_x),
                .i_wr_y  (i_pos_y),
                .i_shift (shift),
                .i_nbr_x (cell_x[(k + 1) % MAX_NODES]),
                .i_nbr_y (cell_y[(k + 1) % MAX_NODES]),
                .o_x     (cell_x[k]),
                .o_y     (cell_y[k])
            );
        end
    endgenerate

    ggnh_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (tag),
        .i_node_x      (head_x),
        .i_node_y      (head_y),
        .i_pkt_x       (r_pkt_x),
        .i_pkt_y       (r_pkt_y),
        .i_sink_x      (r_sink_x),
        .i_sink_y      (r_sink_y),
        .i_radio_range (r_radio_range),
        .i_cap         (r_cap),
        .o_fin         (fin),
        .o_route       (ev_route),
        .o_next        (ev_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sink_x      <= '0;
            r_sink_y      <= '0;
            r_radio_range <= 16'd100;
            r_cap         <= 16'd1000;
            r_node_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SINK_X:   r_sink_x      <= i_cfg_data;
                REG_SINK_Y:   r_sink_y      <= i_cfg_data;
                REG_RANGE:    r_radio_range <= i_cfg_data;
                REG_CAP:      r_cap         <= i_cfg_data;
                REG_NODE_CNT: r_node_count  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_feed      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= fin;
            if (route_go) begin
                r_busy <= 1'b1;
                r_feed <= 1'b1;
                r_step <= '0;
            end else begin
                if (r_feed) begin
                    r_step <= r_step + SW'(1);
                    if (step_last) begin
                        r_feed <= 1'b0;
                    end
                end
                if (fin) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (route_go) begin
            r_pkt_x <= i_pos_x;
            r_pkt_y <= i_pos_y;
        end
        if (fin) begin
            r_out_route <= ev_route;
            r_out_next  <= ev_next;
        end
    end

    assign busy        = r_busy;
    assign o_valid     = r_out_valid;
    assign o_route     = r_out_route;
    assign o_next_node = r_out_next;

endmodule

[rtl/ggnh_cell.sv]
// One table cell: holds one node position and rotates it to its neighbor during a scan.
module ggnh_cell (
    input  logic               i_clk,
    input  logic               i_wr,
    input  logic signed [15:0] i_wr_x,
    input  logic signed [15:0] i_wr_y,
    input  logic               i_shift,
    input  logic signed [15:0] i_nbr_x,
    input  logic signed [15:0] i_nbr_y,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y
);

    logic signed [15:0] r_x;
    logic signed [15:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_shift) begin
            r_x <= i_nbr_x;
            r_y <= i_nbr_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

[rtl/ggnh_eval.sv]
// Distance pipeline and best-candidate tracker fed by the head of the cell chain.
module ggnh_eval (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ggnh_pkg::t_tag     i_tag,
    input  logic signed [15:0] i_node_x,
    input  logic signed [15:0] i_node_y,
    input  logic signed [15:0] i_pkt_x,
    input  logic signed [15:0] i_pkt_y,
    input  logic signed [15:0] i_sink_x,
    input  logic signed [15:0] i_sink_y,
    input  logic [15:0]        i_radio_range,
    input  logic [15:0]        i_cap,
    output logic               o_fin,
    output logic [1:0]         o_route,
    output logic [ggnh_pkg::NEXT_W-1:0] o_next
);

    import ggnh_pkg::*;

    // Stage 1: coordinate differences.
    t_tag               r_tag1;
    logic signed [16:0] r_dxs, r_dys, r_dxp, r_dyp;
    // Stage 2: squares. A 17-bit difference squared always fits in 32 bits.
    t_tag               r_tag2;
    logic [31:0]        r_sxs, r_sys, r_sxp, r_syp;
    // Stage 3: squared distances.
    t_tag               r_tag3;
    logic [32:0]        r_to_sink, r_to_pkt;
    // Squared thresholds.
    logic [31:0]        r_range2, r_cap2;
    // Running decision state.
    logic [32:0]        r_best;
    logic [NEXT_W-1:0]  r_pick;
    logic               r_found, r_pick_zero, r_hit, r_fin;

    logic signed [33:0] sq_xs, sq_ys, sq_xp, sq_yp;
    logic               in_range, better;

    assign sq_xs = r_dxs * r_dxs;
    assign sq_ys = r_dys * r_dys;
    assign sq_xp = r_dxp * r_dxp;
    assign sq_yp = r_dyp * r_dyp;

    assign in_range = r_to_pkt <= {1'b0, r_range2};
    assign better   = r_to_sink <= r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_fin  <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_fin  <= r_tag3.beat && r_tag3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range2 <= i_radio_range * i_radio_range;
        r_cap2   <= i_cap * i_cap;

        r_dxs <= $signed({i_node_x[15], i_node_x}) - $signed({i_sink_x[15], i_sink_x});
        r_dys <= $signed({i_node_y[15], i_node_y}) - $signed({i_sink_y[15], i_sink_y});
        r_dxp <= $signed({i_pkt_x[15], i_pkt_x}) - $signed({i_node_x[15], i_node_x});
        r_dyp <= $signed({i_pkt_y[15], i_pkt_y}) - $signed({i_node_y[15], i_node_y});

        r_sxs <= sq_xs[31:0];
        r_sys <= sq_ys[31:0];
        r_sxp <= sq_xp[31:0];
        r_syp <= sq_yp[31:0];

        r_to_sink <= {1'b0, r_sxs} + {1'b0, r_sys};
        r_to_pkt  <= {1'b0, r_sxp} + {1'b0, r_syp};

        // The sink beat opens every scan and resets the search.
        if (r_tag3.beat) begin
            if (r_tag3.sink) begin
                r_hit   <= in_range;
                r_best  <= {1'b0, r_cap2};
                r_found <= 1'b0;
            end else if (r_tag3.node_ok && in_range && better) begin
                r_best      <= r_to_sink;
                r_pick      <= r_tag3.idx;
                r_found     <= 1'b1;
                r_pick_zero <= r_to_pkt == '0;
            end
        end
    end

    always_comb begin
        o_route = ROUTE_NONE;
        o_next  = '0;
        if (r_hit) begin
            o_route = ROUTE_SINK;
        end else if (r_found && !r_pick_zero) begin
            o_route = ROUTE_NODE;
            o_next  = r_pick;
        end
    end

    assign o_fin = r_fin;

endmodule
